[rtl/core/metering_chip_poll_controller_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the metering chip poll controller
// Clocked, reset-qualified same-cycle and next-cycle implication checks.
// ----------------------------------------------------------------------------
`ifndef METERING_CHIP_POLL_CONTROLLER_ASSERT_SVH
`define METERING_CHIP_POLL_CONTROLLER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PCC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PCC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/pcc_pkg.sv]
// ----------------------------------------------------------------------------
// pcc_pkg
// Shared types and constants of the metering chip poll controller.
// ----------------------------------------------------------------------------
package pcc_pkg;

    localparam int BYTE_W     = 8;
    localparam int DATA_W     = 24;
    localparam int TIMER_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 56;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_READ_COMMAND   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ADDR_CURRENT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ADDR_VOLTAGE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ADDR_POWER     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ADDR_PULSE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_AUTO_ENABLE    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_POLL_PERIOD    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS  = 3'd7;

    // Reset values of the timing registers.
    localparam logic [TIMER_W-1:0] POLL_PERIOD_RST   = 16'd2000;
    localparam logic [TIMER_W-1:0] TIMEOUT_TICKS_RST = 16'd200;

    // Measurement channels.
    localparam logic [1:0] CH_VOLTAGE = 2'd0;
    localparam logic [1:0] CH_CURRENT = 2'd1;
    localparam logic [1:0] CH_POWER   = 2'd2;
    localparam logic [1:0] CH_PULSE   = 2'd3;

    localparam logic [2:0]        MAX_RETRIES   = 3'd5;
    localparam logic [2:0]        ROUND_READS   = 3'd4;
    localparam logic [DATA_W-1:0] SIGN_MASK     = 24'h800000;
    localparam logic [DATA_W-1:0] MAG_MASK      = 24'h7FFFFF;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_REPLY = 2'd1,
        OP_POLL  = 2'd2
    } t_op;

    typedef enum logic {
        KIND_FRAME = 1'b0,
        KIND_VALUE = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_ARMED    = 2'd1,
        PH_COUNTING = 2'd2
    } t_phase;

    typedef struct packed {
        logic [BYTE_W-1:0]  read_command;
        logic [BYTE_W-1:0]  addr_current;
        logic [BYTE_W-1:0]  addr_voltage;
        logic [BYTE_W-1:0]  addr_power;
        logic [BYTE_W-1:0]  addr_pulse_count;
        logic               auto_enable;
        logic [TIMER_W-1:0] poll_period;
        logic [TIMER_W-1:0] timeout_ticks;
    } t_cfg;

    typedef struct packed {
        logic [1:0]        operation;
        logic [DATA_W-1:0] reply_data;
        logic [BYTE_W-1:0] reply_checksum;
    } t_item;

    typedef struct packed {
        t_kind             kind;
        logic [BYTE_W-1:0] frame_command;
        logic [BYTE_W-1:0] frame_address;
        logic [BYTE_W-1:0] frame_checksum;
        logic [1:0]        channel;
        logic [DATA_W-1:0] value;
    } t_result;

endpackage

[rtl/core/pcc_cfg.sv]
// ----------------------------------------------------------------------------
// pcc_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module pcc_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [pcc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pcc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output pcc_pkg::t_cfg                     o_cfg
);
    import pcc_pkg::*;

    t_cfg r_cfg;

    // Register writes; unused upper data bits are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.read_command     <= '0;
            r_cfg.addr_current     <= '0;
            r_cfg.addr_voltage     <= '0;
            r_cfg.addr_power       <= '0;
            r_cfg.addr_pulse_count <= '0;
            r_cfg.auto_enable      <= 1'b1;
            r_cfg.poll_period      <= POLL_PERIOD_RST;
            r_cfg.timeout_ticks    <= TIMEOUT_TICKS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_READ_COMMAND:  r_cfg.read_command     <= i_cfg_data[BYTE_W-1:0];
                REG_ADDR_CURRENT:  r_cfg.addr_current     <= i_cfg_data[BYTE_W-1:0];
                REG_ADDR_VOLTAGE:  r_cfg.addr_voltage     <= i_cfg_data[BYTE_W-1:0];
                REG_ADDR_POWER:    r_cfg.addr_power       <= i_cfg_data[BYTE_W-1:0];
                REG_ADDR_PULSE:    r_cfg.addr_pulse_count <= i_cfg_data[BYTE_W-1:0];
                REG_AUTO_ENABLE:   r_cfg.auto_enable      <= i_cfg_data[0];
                REG_POLL_PERIOD:   r_cfg.poll_period      <= i_cfg_data[TIMER_W-1:0];
                REG_TIMEOUT_TICKS: r_cfg.timeout_ticks    <= i_cfg_data[TIMER_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/core/pcc_core.sv]
// ----------------------------------------------------------------------------
// pcc_core
// Poll state registers and the single-pass update logic for one item.
// ----------------------------------------------------------------------------
module pcc_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pcc_pkg::t_cfg    i_cfg,
    input  logic             i_valid,
    input  pcc_pkg::t_item   i_item,
    output logic             o_res_valid,
    output pcc_pkg::t_result o_res
);
    import pcc_pkg::*;

    logic [2:0]         r_pending, n_pending;
    logic               r_busy, n_busy;
    logic [1:0]         r_cur, n_cur;
    logic [2:0]         r_retry, n_retry;
    t_phase             r_phase, n_phase;
    logic [TIMER_W-1:0] r_tmo_cnt, n_tmo_cnt;
    logic               r_timed_out, n_timed_out;
    logic [TIMER_W-1:0] r_poll_tmr, n_poll_tmr;

    // Chip register address of a channel.
    function automatic logic [BYTE_W-1:0] chan_addr(input t_cfg cfg, input logic [1:0] ch);
        logic [BYTE_W-1:0] a;
        unique case (ch)
            CH_VOLTAGE: a = cfg.addr_voltage;
            CH_CURRENT: a = cfg.addr_current;
            CH_POWER:   a = cfg.addr_power;
            default:    a = cfg.addr_pulse_count;
        endcase
        return a;
    endfunction

    // Read frame: command, address and 0xFF minus their byte sum.
    function automatic t_result make_frame(input t_cfg cfg, input logic [1:0] ch);
        t_result f;
        logic [BYTE_W-1:0] a;
        a                = chan_addr(cfg, ch);
        f                = '0;
        f.kind           = KIND_FRAME;
        f.frame_command  = cfg.read_command;
        f.frame_address  = a;
        f.frame_checksum = ~(cfg.read_command + a);
        f.channel        = ch;
        return f;
    endfunction

    logic [BYTE_W-1:0]  sum;
    logic [2:0]         rc1;
    logic               retry_ok;
    logic               issued;
    logic               busy_v;
    logic [TIMER_W-1:0] cnt;
    logic [TIMER_W-1:0] ptm;
    logic [DATA_W-1:0]  val;
    logic [1:0]         fresh_ch;
    logic               fresh_hit;

    // Next state and result for the item at the input register.
    always_comb begin
        n_pending   = r_pending;
        n_busy      = r_busy;
        n_cur       = r_cur;
        n_retry     = r_retry;
        n_phase     = r_phase;
        n_tmo_cnt   = r_tmo_cnt;
        n_timed_out = r_timed_out;
        n_poll_tmr  = r_poll_tmr;
        o_res_valid = 1'b0;
        o_res       = '0;
        sum         = i_cfg.read_command + chan_addr(i_cfg, r_cur)
                      + i_item.reply_data[23:16] + i_item.reply_data[15:8]
                      + i_item.reply_data[7:0];
        rc1         = r_retry + 3'd1;
        retry_ok    = (rc1 <= MAX_RETRIES) && (rc1 != 3'd0);
        issued      = 1'b0;
        busy_v      = r_busy;
        cnt         = '0;
        ptm         = '0;
        val         = '0;
        fresh_ch    = CH_VOLTAGE;
        fresh_hit   = 1'b0;

        unique case (t_op'(i_item.operation))
            OP_TICK: begin
                // Reply timeout of the read in flight.
                if (r_phase != PH_IDLE) begin
                    cnt = ((r_phase == PH_ARMED) ? '0 : r_tmo_cnt) + 16'd1;
                    if (cnt >= i_cfg.timeout_ticks) begin
                        n_tmo_cnt   = '0;
                        n_phase     = PH_IDLE;
                        n_timed_out = 1'b1;
                    end else begin
                        n_tmo_cnt = cnt;
                        n_phase   = PH_COUNTING;
                    end
                end else begin
                    n_tmo_cnt = '0;
                end
                // Periodic poll round.
                if (i_cfg.auto_enable) begin
                    ptm = r_poll_tmr + 16'd1;
                    if (ptm >= i_cfg.poll_period) begin
                        n_poll_tmr = '0;
                        n_pending  = ROUND_READS;
                        n_busy     = 1'b0;
                    end else begin
                        n_poll_tmr = ptm;
                    end
                end else begin
                    n_poll_tmr = '0;
                end
            end
            OP_REPLY: begin
                if (r_busy) begin
                    if (i_item.reply_checksum != ~sum) begin
                        // Bad reply: resend or give up.
                        if (retry_ok) begin
                            n_retry     = rc1;
                            n_phase     = PH_ARMED;
                            n_timed_out = 1'b0;
                            n_busy      = 1'b1;
                            o_res_valid = 1'b1;
                            o_res       = make_frame(i_cfg, r_cur);
                        end else begin
                            n_retry     = '0;
                            n_phase     = PH_IDLE;
                            n_timed_out = 1'b0;
                            n_busy      = 1'b0;
                        end
                    end else begin
                        // Good reply: power reported as a magnitude.
                        val = i_item.reply_data;
                        if (r_cur == CH_POWER) begin
                            if ((i_item.reply_data & SIGN_MASK) != '0) begin
                                val = ((~i_item.reply_data) & MAG_MASK) + 24'd1;
                            end else begin
                                val = i_item.reply_data & MAG_MASK;
                            end
                        end
                        o_res_valid   = 1'b1;
                        o_res.kind    = KIND_VALUE;
                        o_res.channel = r_cur;
                        o_res.value   = val;
                        n_retry       = '0;
                        n_phase       = PH_IDLE;
                        n_timed_out   = 1'b0;
                        n_busy        = 1'b0;
                    end
                end
            end
            OP_POLL: begin
                // A timed-out read is resent first, or abandoned.
                if (r_timed_out) begin
                    n_timed_out = 1'b0;
                    if (retry_ok) begin
                        issued      = 1'b1;
                        n_retry     = rc1;
                        n_phase     = PH_ARMED;
                        n_busy      = 1'b1;
                        o_res_valid = 1'b1;
                        o_res       = make_frame(i_cfg, r_cur);
                    end else begin
                        busy_v  = 1'b0;
                        n_retry = '0;
                        n_phase = PH_IDLE;
                        n_busy  = 1'b0;
                    end
                end
                // Next queued read: pulse count, power, voltage, current.
                if (!issued && !busy_v && r_pending != 3'd0) begin
                    n_pending = r_pending - 3'd1;
                    priority case (r_pending)
                        3'd1: begin fresh_ch = CH_CURRENT; fresh_hit = 1'b1; end
                        3'd2: begin fresh_ch = CH_VOLTAGE; fresh_hit = 1'b1; end
                        3'd3: begin fresh_ch = CH_POWER;   fresh_hit = 1'b1; end
                        3'd4: begin fresh_ch = CH_PULSE;   fresh_hit = 1'b1; end
                        default: ;
                    endcase
                    if (fresh_hit) begin
                        n_cur       = fresh_ch;
                        n_retry     = '0;
                        n_phase     = PH_ARMED;
                        n_timed_out = 1'b0;
                        n_busy      = 1'b1;
                        o_res_valid = 1'b1;
                        o_res       = make_frame(i_cfg, fresh_ch);
                    end
                end
            end
            default: ;
        endcase
    end

    // State registers advance once per processed item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending   <= '0;
            r_busy      <= 1'b0;
            r_cur       <= CH_VOLTAGE;
            r_retry     <= '0;
            r_phase     <= PH_IDLE;
            r_tmo_cnt   <= '0;
            r_timed_out <= 1'b0;
            r_poll_tmr  <= '0;
        end else if (i_valid) begin
            r_pending   <= n_pending;
            r_busy      <= n_busy;
            r_cur       <= n_cur;
            r_retry     <= n_retry;
            r_phase     <= n_phase;
            r_tmo_cnt   <= n_tmo_cnt;
            r_timed_out <= n_timed_out;
            r_poll_tmr  <= n_poll_tmr;
        end
    end

endmodule

[rtl/core/metering_chip_poll_controller.sv]
// ----------------------------------------------------------------------------
// metering_chip_poll_controller
// Poll controller for an energy-metering chip: timer ticks, read frames,
// reply checking with retries, and channel values.
// ----------------------------------------------------------------------------
// The block takes one word per clock cycle while the output is not stalled.
// A word is caught in an input register, handled by one pass of the poll
// logic once the output register can take a word, and its result word, if
// any, is held in an output register. The output register drains while the
// next word is taken; input ready only drops while a result waits unaccepted
// and the input register is full.
module metering_chip_poll_controller (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Slave side: tdata = reply_data[23:0], reply_checksum[31:24].
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [pcc_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // tuser = operation[1:0].
    input  logic [1:0]                       s_axis_tuser,
    // Master side: tdata = frame_command[7:0], frame_address[15:8],
    // frame_checksum[23:16], channel[25:24], value[49:26], zero fill above.
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [pcc_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    // tuser = kind[0].
    output logic                             m_axis_tuser,
    // Configuration write port.
    input  logic                             i_cfg_we,
    input  logic [pcc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [pcc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import pcc_pkg::*;

    t_cfg    cfg;
    t_item   r_in;
    logic    r_in_valid;
    logic    advance;
    logic    res_valid;
    t_result res;
    t_result r_out;
    logic    r_out_valid;

    pcc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Input register moves on whenever the output register can take a word.
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in.operation      <= s_axis_tuser;
            r_in.reply_data     <= s_axis_tdata[DATA_W-1:0];
            r_in.reply_checksum <= s_axis_tdata[S_TDATA_W-1:DATA_W];
        end
    end

    pcc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_valid     (advance),
        .i_item      (r_in),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= res_valid;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && res_valid) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tdata  = {6'b0, r_out.value, r_out.channel, r_out.frame_checksum,
                            r_out.frame_address, r_out.frame_command};

endmodule

[rtl/core/pcc_checker.sv]
// ----------------------------------------------------------------------------
// pcc_checker
// Port-level checks of the poll controller's result stream.
// ----------------------------------------------------------------------------
`include "metering_chip_poll_controller_assert.svh"

module pcc_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [pcc_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    input logic                             m_axis_tuser
);
    import pcc_pkg::*;

    // A stalled result word holds.
    `PCC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result word changed while stalled")

    // A read frame carries a correct checksum and no value.
    `PCC_ASSERT_SAME(a_frame_ok, m_axis_tvalid && (m_axis_tuser == KIND_FRAME), (m_axis_tdata[23:16] == 8'(~(m_axis_tdata[7:0] + m_axis_tdata[15:8]))) && (m_axis_tdata[49:26] == '0), "bad read frame")

    // A value word carries no frame bytes.
    `PCC_ASSERT_SAME(a_value_clean, m_axis_tvalid && (m_axis_tuser == KIND_VALUE), m_axis_tdata[23:0] == '0, "value word with frame bytes")

    // Power magnitude never exceeds the largest negative reading.
    `PCC_ASSERT_SAME(a_power_mag, m_axis_tvalid && (m_axis_tuser == KIND_VALUE) && (m_axis_tdata[25:24] == CH_POWER), m_axis_tdata[49:26] <= SIGN_MASK, "power magnitude out of range")

endmodule

bind metering_chip_poll_controller pcc_checker u_pcc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
